@@ rtl/core/swma_pkg.sv @@
package swma_pkg;

    localparam int SAMPLE_W = 8;
    localparam int CFG_W    = 11;
    localparam int TWICE_W  = 9;
    localparam int ALERT_W  = 24;

    localparam logic [ALERT_W-1:0] ALERT_MAX = {ALERT_W{1'b1}};

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_SCAN,
        OP_DLY_RD,
        OP_OLD_RD,
        OP_OLD_WR,
        OP_INC_RD,
        OP_COMMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic cnt_clr;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic cnt_last;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/core/swma_if.sv @@
interface swma_in_if;
    import swma_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swma_out_if;
    import swma_pkg::*;

    logic               valid;
    logic               ready;
    logic               window_full;
    logic               alert;
    logic [TWICE_W-1:0] twice_median;
    logic [ALERT_W-1:0] alert_total;

    modport source (output valid, output window_full, output alert,
                    output twice_median, output alert_total, input ready);
    modport sink   (input valid, input window_full, input alert,
                    input twice_median, input alert_total, output ready);
endinterface

@@ rtl/core/swma_ram.sv @@
module swma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/swma_ctrl.sv @@
module swma_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_in_valid,
    input  swma_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output swma_pkg::t_cmd o_cmd
);
    import swma_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DLY_RD,
        ST_OLD_RD,
        ST_OLD_WR,
        ST_INC_RD,
        ST_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    t_cmd   cmd;

    always_comb begin
        n_state     = r_state;
        cmd.op      = OP_NONE;
        cmd.cnt_clr = 1'b0;
        if (i_cfg_we) begin
            // restart the window: sweep the histogram again
            n_state     = ST_CLEAR;
            cmd.cnt_clr = 1'b1;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    cmd.op = OP_CLEAR;
                    if (i_sts.cnt_last) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid && r_ready) begin
                        cmd.op      = OP_LOAD;
                        cmd.cnt_clr = 1'b1;
                        n_state     = i_sts.full ? ST_SCAN : ST_INC_RD;
                    end
                end
                ST_SCAN: begin
                    cmd.op = OP_SCAN;
                    if (i_sts.cnt_last) begin
                        n_state = ST_DLY_RD;
                    end
                end
                ST_DLY_RD: begin
                    cmd.op  = OP_DLY_RD;
                    n_state = ST_OLD_RD;
                end
                ST_OLD_RD: begin
                    cmd.op  = OP_OLD_RD;
                    n_state = ST_OLD_WR;
                end
                ST_OLD_WR: begin
                    cmd.op  = OP_OLD_WR;
                    n_state = ST_INC_RD;
                end
                ST_INC_RD: begin
                    cmd.op  = OP_INC_RD;
                    n_state = ST_COMMIT;
                end
                ST_COMMIT: begin
                    // hold until the output word slot frees up
                    if (i_sts.out_free) begin
                        cmd.op  = OP_COMMIT;
                        n_state = ST_IDLE;
                    end
                end
                default: begin
                    n_state = ST_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == ST_IDLE);
        end
    end

    assign o_in_ready = r_ready;
    assign o_cmd      = cmd;

endmodule

@@ rtl/core/swma_dp.sv @@
module swma_dp #(
    parameter int VALUE_BINS = 256,
    parameter int MAX_WINDOW = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swma_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [swma_pkg::SAMPLE_W-1:0] i_sample,
    input  swma_pkg::t_cmd                i_cmd,
    output swma_pkg::t_sts                o_sts,
    swma_out_if.source                    o_out
);
    import swma_pkg::*;

    localparam int BW = $clog2(VALUE_BINS);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int PW = $clog2(MAX_WINDOW);
    localparam int OW = CW + 1;

    function automatic logic [SAMPLE_W-1:0] sat_bin(input logic [SAMPLE_W-1:0] v);
        if (32'(v) >= VALUE_BINS) begin
            return SAMPLE_W'(VALUE_BINS - 1);
        end
        return v;
    endfunction

    logic [CW-1:0]       r_len;
    logic [CW-1:0]       r_fill;
    logic [PW-1:0]       r_wp;
    logic [ALERT_W-1:0]  r_alert_cnt;
    logic [BW-1:0]       r_cnt;
    logic [SAMPLE_W-1:0] r_s;
    logic                r_full;
    logic                r_acc_v;
    logic [BW-1:0]       r_acc_bin;
    logic [CW-1:0]       r_cum;
    logic [BW-1:0]       r_lo;
    logic [BW-1:0]       r_hi;
    logic                r_lo_f;
    logic                r_hi_f;
    logic [BW-1:0]       r_old;
    logic                r_ov;
    logic                r_o_full;
    logic                r_o_alert;
    logic [TWICE_W-1:0]  r_o_twice;

    logic [CW-1:0]       n_len;
    logic [PW-1:0]       n_wp;
    logic [OW-1:0]       n_cum;

    logic                h_we;
    logic [BW-1:0]       h_waddr;
    logic [CW-1:0]       h_wdata;
    logic                h_re;
    logic [BW-1:0]       h_raddr;
    logic [CW-1:0]       h_rdata;
    logic                d_we;
    logic                d_re;
    logic [SAMPLE_W-1:0] d_rdata;

    logic [OW-1:0]       old_sum;
    logic [PW-1:0]       old_idx;
    logic [CW-1:0]       rank_lo;
    logic [CW-1:0]       rank_hi;
    logic [BW:0]         twice;
    logic                alert;
    logic [BW-1:0]       s_bin;
    logic [BW-1:0]       old_bin;

    assign n_len = (i_cfg_data == '0)              ? CW'(1) :
                   (32'(i_cfg_data) > MAX_WINDOW)  ? CW'(MAX_WINDOW) :
                                                     CW'(i_cfg_data);

    assign n_wp    = (r_wp == PW'(MAX_WINDOW - 1)) ? '0 : r_wp + PW'(1);
    assign old_sum = OW'(r_wp) + OW'(MAX_WINDOW) - OW'(r_len);
    assign old_idx = (old_sum >= OW'(MAX_WINDOW)) ? PW'(old_sum - OW'(MAX_WINDOW))
                                                  : PW'(old_sum);

    assign rank_lo = (r_len - CW'(1)) >> 1;
    assign rank_hi = r_len >> 1;
    assign n_cum   = OW'(r_cum) + OW'(h_rdata);
    assign twice   = (BW + 1)'(r_lo) + (BW + 1)'(r_hi);
    assign alert   = r_full && (32'(r_s) >= 32'(twice));
    assign s_bin   = BW'(r_s);
    assign old_bin = BW'(sat_bin(d_rdata));

    always_comb begin
        h_we    = 1'b0;
        h_waddr = r_cnt;
        h_wdata = '0;
        h_re    = 1'b0;
        h_raddr = r_cnt;
        d_we    = 1'b0;
        d_re    = 1'b0;
        case (i_cmd.op)
            OP_CLEAR: begin
                h_we = 1'b1;
            end
            OP_SCAN: begin
                h_re = 1'b1;
            end
            OP_DLY_RD: begin
                d_re = 1'b1;
            end
            OP_OLD_RD: begin
                h_re    = 1'b1;
                h_raddr = old_bin;
            end
            OP_OLD_WR: begin
                h_we    = 1'b1;
                h_waddr = r_old;
                h_wdata = (h_rdata != '0) ? h_rdata - CW'(1) : '0;
            end
            OP_INC_RD: begin
                h_re    = 1'b1;
                h_raddr = s_bin;
            end
            OP_COMMIT: begin
                h_we    = 1'b1;
                h_waddr = s_bin;
                h_wdata = h_rdata + CW'(1);
                d_we    = 1'b1;
            end
            default: begin
                h_we = 1'b0;
            end
        endcase
    end

    swma_ram #(
        .WIDTH (CW),
        .DEPTH (VALUE_BINS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    swma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_dly (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (r_wp),
        .i_wdata (r_s),
        .i_re    (d_re),
        .i_raddr (old_idx),
        .o_rdata (d_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= CW'(1);
            r_fill      <= '0;
            r_wp        <= '0;
            r_alert_cnt <= '0;
            r_cnt       <= '0;
            r_acc_v     <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_acc_v <= (i_cmd.op == OP_SCAN);
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.op == OP_CLEAR || i_cmd.op == OP_SCAN) begin
                r_cnt <= r_cnt + BW'(1);
            end
            if (i_cfg_we) begin
                r_len  <= n_len;
                r_fill <= '0;
                r_wp   <= '0;
            end else if (i_cmd.op == OP_COMMIT) begin
                r_wp <= n_wp;
                if (!r_full) begin
                    r_fill <= r_fill + CW'(1);
                end
                if (alert && r_alert_cnt != ALERT_MAX) begin
                    r_alert_cnt <= r_alert_cnt + ALERT_W'(1);
                end
            end
            if (i_cmd.op == OP_COMMIT) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_acc_bin <= r_cnt;
        if (i_cmd.op == OP_LOAD) begin
            r_s    <= sat_bin(i_sample);
            r_full <= (r_fill >= r_len);
            r_cum  <= '0;
            r_lo   <= '0;
            r_hi   <= '0;
            r_lo_f <= 1'b0;
            r_hi_f <= 1'b0;
        end else if (r_acc_v) begin
            r_cum <= CW'(n_cum);
            if (!r_lo_f && n_cum > OW'(rank_lo)) begin
                r_lo   <= r_acc_bin;
                r_lo_f <= 1'b1;
            end
            if (!r_hi_f && n_cum > OW'(rank_hi)) begin
                r_hi   <= r_acc_bin;
                r_hi_f <= 1'b1;
            end
        end
        if (i_cmd.op == OP_OLD_RD) begin
            r_old <= old_bin;
        end
        if (i_cmd.op == OP_COMMIT) begin
            r_o_full  <= r_full;
            r_o_alert <= alert;
            r_o_twice <= r_full ? TWICE_W'(twice) : '0;
        end
    end

    assign o_sts.full     = (r_fill >= r_len);
    assign o_sts.cnt_last = (r_cnt == BW'(VALUE_BINS - 1));
    assign o_sts.out_free = !r_ov || o_out.ready;

    assign o_out.valid        = r_ov;
    assign o_out.window_full  = r_o_full;
    assign o_out.alert        = r_o_alert;
    assign o_out.twice_median = r_o_twice;
    assign o_out.alert_total  = r_alert_cnt;

endmodule

@@ rtl/core/sliding_window_median_alert_unit.sv @@
// Sliding-window median alert. Each input word carries one 8-bit sample; each
// sample yields one output word. The unit keeps a histogram of the samples in
// the window (a VALUE_BINS-entry RAM) and a delay line of the last window_length
// samples (a MAX_WINDOW-entry RAM). While the window fills, a sample only enters
// it. Once the window is full, the histogram RAM is scanned one bin per cycle to
// find the two middle ranks, then the oldest sample is read from the delay line
// and removed, and the new one is added; the scan goes through the single read
// port of the histogram RAM. The output word reports twice the median, whether
// the sample reached it, and a saturating alert count; it is held in an output
// register, so a new sample is taken while it waits, and the next result holds
// at commit until the pending word is taken.
// After reset and after every window_length write the histogram is cleared by a
// pass over all VALUE_BINS bins, during which no sample is accepted. A window_length
// write restarts the window and keeps the alert count; write it only when idle.
module sliding_window_median_alert_unit #(
    parameter int VALUE_BINS = 256,
    parameter int MAX_WINDOW = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [swma_pkg::CFG_W-1:0] i_cfg_data,
    swma_in_if.sink                    i_in,
    swma_out_if.source                 o_out
);
    import swma_pkg::*;

    // command and status between the sequencer and the datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: clear pass, accept, scan, remove oldest, add newest, commit
    swma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // datapath: both RAMs, rank search, counters and the output word register
    swma_dp #(
        .VALUE_BINS (VALUE_BINS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_in.sample),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

`ifndef SYNTH
    // accepting a word drops ready on the next cycle: one sample in flight
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while a sample was in flight");

    // commit only into a free output slot, never over an untaken word
    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_COMMIT) |-> (!o_out.valid || o_out.ready))
        else $error("commit would overwrite a pending output word");

    // a commit always shows up as a valid output word
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_COMMIT) |=> o_out.valid)
        else $error("committed result missing on the output");
`endif

endmodule

@@ bench/tb_sliding_window_median_alert_unit.sv @@
module tb_sliding_window_median_alert_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import swma_pkg::*;

    localparam int VALUE_BINS  = 256;
    localparam int MAX_WINDOW  = 1024;
    localparam int QUIET_LIMIT = 5000;   // clear pass + one full scan, several times over
    localparam int RANDOM_ITEMS = 540;

    typedef struct packed {
        logic               full;
        logic               alert;
        logic [TWICE_W-1:0] twice;
        logic [ALERT_W-1:0] total;
    } t_median_word;

    // Mirror of the unit: histogram, delay line and alert count, plus the
    // queue of output words still owed by the unit.
    class median_scoreboard;
        int unsigned         value_hist[VALUE_BINS];
        logic [SAMPLE_W-1:0] delay_line[MAX_WINDOW];
        logic [9:0]          wr_ptr;
        logic [CFG_W-1:0]    fill_cnt;
        logic [CFG_W-1:0]    win_len;
        logic [ALERT_W-1:0]  alert_cnt;
        t_median_word        owed_words[$];
        int unsigned         errors;

        function new();
            alert_cnt = '0;
            errors    = 0;
            load_window(11'd1);
        endfunction

        // A length write restarts the window; the alert count survives.
        function void load_window(logic [CFG_W-1:0] len);
            win_len  = len;
            wr_ptr   = '0;
            fill_cnt = '0;
            foreach (value_hist[v]) value_hist[v] = 0;
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction

        function int unsigned value_at_rank(int unsigned r);
            int unsigned acc;
            acc = 0;
            for (int v = 0; v < VALUE_BINS; v++) begin
                acc += value_hist[v];
                if (acc > r) return v;
            end
            return 0;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            t_median_word w;
            int unsigned  eff;
            int unsigned  old_idx;
            logic [SAMPLE_W-1:0] old;
            w   = '0;
            eff = (win_len == 0) ? 1 : (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
            if (fill_cnt >= eff) begin
                w.full  = 1'b1;
                w.twice = TWICE_W'(value_at_rank((eff - 1) / 2) + value_at_rank(eff / 2));
                if ({1'b0, s} >= w.twice) begin
                    w.alert = 1'b1;
                    if (alert_cnt != ALERT_MAX) alert_cnt++;
                end
                old_idx = (int'(wr_ptr) + MAX_WINDOW - eff) % MAX_WINDOW;
                old     = delay_line[old_idx];
                if (value_hist[old] > 0) value_hist[old]--;
            end else begin
                fill_cnt++;
            end
            value_hist[s]++;
            delay_line[wr_ptr] = s;
            wr_ptr++;
            w.total = alert_cnt;
            owed_words.push_back(w);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_word(logic full, logic alert, logic [TWICE_W-1:0] twice,
                        logic [ALERT_W-1:0] total);
            t_median_word w;
            if (owed_words.size() == 0) begin
                report("output word with nothing owed");
                return;
            end
            w = owed_words.pop_front();
            if (full !== w.full)
                report($sformatf("window_full %b, want %b", full, w.full));
            if (alert !== w.alert)
                report($sformatf("alert %b, want %b", alert, w.alert));
            if (twice !== w.twice)
                report($sformatf("twice_median %0d, want %0d", twice, w.twice));
            if (total !== w.total)
                report($sformatf("alert_total %0d, want %0d", total, w.total));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               steady;        // both sides stop idling while set
    int unsigned        quiet_cycles = 0;
    median_scoreboard   sb;

    swma_in_if  in_if ();
    swma_out_if out_if ();

    sliding_window_median_alert_unit #(
        .VALUE_BINS (VALUE_BINS),
        .MAX_WINDOW (MAX_WINDOW)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Output side: stall about 16 percent of the time unless in a steady stretch.
    always @(posedge i_clk) begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= 16);
    end

    // Check every output word at the edge where it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_word(out_if.window_full, out_if.alert, out_if.twice_median,
                          out_if.alert_total);
    end

    // Watchdog: count edges with no word moving on either side.
    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_sliding_window_median_alert_unit failed");
            $finish;
        end
    end

    // Offer one sample; hold valid until the unit takes it. Valid stays high
    // on return so back-to-back words need no second assignment in a step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < 16) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= value;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_sample(value);
    endtask

    // Drop valid and hold until every owed output word has come back.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write window_length only when idle; the unit then runs its clear pass.
    task automatic write_window(input logic [CFG_W-1:0] len);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.load_window(len);
    endtask

    // Samples cluster around a level, with some near twice the level so the
    // compare goes both ways, and a few anywhere in range.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int level);
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            v = level + int'($urandom_range(0, 8)) - 4;
        else if (pick < 85)
            v = 2 * level + int'($urandom_range(0, 4)) - 2;
        else
            v = $urandom_range(0, 255);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return SAMPLE_W'(v);
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] one_back[$];
        logic [SAMPLE_W-1:0] pair_window[$];
        int unsigned         sent;
        int unsigned         phase;
        int unsigned         len;
        int unsigned         count;
        int                  level;

        one_back    = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd127, 8'd254,
                        8'd1, 8'd2, 8'd3, 8'h55, 8'hAA, 8'd128, 8'd64};
        pair_window = '{8'd200, 8'd40, 8'd100, 8'd240, 8'd239, 8'd255};

        sb = new();
        steady       = 1'b0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_data   <= '0;
        in_if.valid  <= 1'b0;
        in_if.sample <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of one: every sample is compared with twice the last one,
        // covering both extremes and the exact-equal case.
        foreach (one_back[k]) send_sample(one_back[k]);

        // Length zero acts as one.
        write_window(11'd0);
        send_sample(8'd10);
        send_sample(8'd20);
        send_sample(8'd19);

        // Even window: twice the median is the sum of the two held samples.
        write_window(11'd2);
        foreach (pair_window[k]) send_sample(pair_window[k]);

        // All-ones length saturates to the deepest window: a short run stays filling.
        write_window(11'h7FF);
        for (int k = 0; k < 24; k++) send_sample(SAMPLE_W'($urandom_range(0, 255)));

        // Random phases: mostly short windows, each filled then slid well past full.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            len   = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 100);
            count = len + $urandom_range(10, 40);
            level = $urandom_range(0, 100);
            write_window(CFG_W'(len));
            steady = (phase == 2);
            for (int unsigned k = 0; k < count; k++) begin
                // Hold the sender once mid-phase until the unit has caught up.
                if (phase == 1 && k == len + 3) drain();
                send_sample(pick_sample(level));
            end
            steady = 1'b0;
            sent  += count;
            phase++;
        end

        // Back to the smallest window at the end.
        write_window(11'd1);
        send_sample(8'd255);
        send_sample(8'd0);
        send_sample(8'd0);

        drain();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_sliding_window_median_alert_unit passed");
        else
            $display("tb_sliding_window_median_alert_unit failed");
        $finish;
    end

endmodule
